// File: src/fisqrt_pkg.sv
// ============================================================================
// fisqrt_pkg
// Shared constants and binary32 arithmetic helpers for the fast inverse
// square root pipeline (round to nearest even, subnormals kept).
// ============================================================================
package fisqrt_pkg;

    localparam int          FP_W        = 32;
    localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
    localparam logic [31:0] FP_HALF     = 32'h3f000000;  // 0.5
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;  // 1.5
    localparam logic [31:0] FP_QNAN_BIT = 32'h00400000;
    localparam logic [31:0] FP_DEFAULT_NAN = 32'hffc00000;
    localparam int          PIPE_DEPTH  = 5;

    // Integer first guess: magic minus arithmetic shift right by one.
    function automatic logic [31:0] first_guess(input logic [31:0] x);
        logic [31:0] sh;
        begin
            sh = {x[31], x[31:1]};
            return MAGIC_GUESS - sh;
        end
    endfunction

    // Normalize, denormalize if needed, round to nearest even and pack.
    // value = sig * 2^(be - 174), sig nonzero.
    function automatic logic [31:0] round_pack(input logic s,
                                               input logic signed [11:0] be,
                                               input logic [47:0] sig);
        logic [5:0]         lz;
        logic [47:0]        n;
        logic [47:0]        n2;
        logic [47:0]        lostm;
        logic signed [11:0] e;
        logic [11:0]        shamt;
        logic               lost;
        logic               rb;
        logic               st;
        logic               inc;
        logic [23:0]        m;
        logic [7:0]         ef;
        logic [31:0]        base;
        logic [31:0]        res;
        begin
            lz = 6'd0;
            for (int i = 0; i < 48; i++) begin
                if (sig[i]) lz = 6'(47 - i);
            end
            n = sig << lz;
            e = be - $signed({6'd0, lz});
            if (e >= 12'sd255) return {s, 8'hff, 23'd0};
            if (e < 12'sd1) begin
                shamt = 12'(12'sd1 - e);
                if (shamt >= 12'd48) begin
                    n2   = 48'd0;
                    lost = |n;
                end else begin
                    n2    = n >> shamt;
                    lostm = (48'd1 << shamt) - 48'd1;
                    lost  = |(n & lostm);
                end
            end else begin
                n2   = n;
                lost = 1'b0;
            end
            m   = n2[47:24];
            rb  = n2[23];
            st  = (|n2[22:0]) | lost;
            inc = rb & (st | m[0]);
            ef  = (e >= 12'sd1) ? 8'(e - 12'sd1) : 8'd0;
            base = {1'b0, ef, 23'd0} + {8'd0, m};
            res  = base + {31'd0, inc};
            if (res[30:23] == 8'hff) return {s, 8'hff, 23'd0};
            return {s, res[30:0]};
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               an, bn, ai, bi, az, bz;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        p;
        logic signed [11:0] be;
        begin
            s  = a[31] ^ b[31];
            an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
            bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
            ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
            bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
            az = (a[30:0] == 31'd0);
            bz = (b[30:0] == 31'd0);
            if (an) return a | FP_QNAN_BIT;
            if (bn) return b | FP_QNAN_BIT;
            if ((ai && bz) || (bi && az)) return FP_DEFAULT_NAN;
            if (ai || bi) return {s, 8'hff, 23'd0};
            if (az || bz) return {s, 31'd0};
            ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
            eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
            ma = {(a[30:23] != 8'd0), a[22:0]};
            mb = {(b[30:23] != 8'd0), b[22:0]};
            p  = {24'd0, ma} * {24'd0, mb};
            be = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
            return round_pack(s, be, p);
        end
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic               an, bn, ai, bi;
        logic [31:0]        big, sml;
        logic [7:0]         eb, es, d;
        logic [26:0]        mb27, ms27, al, stm;
        logic [27:0]        sum;
        logic signed [11:0] be;
        begin
            an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
            bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
            ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
            bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
            if (an) return a | FP_QNAN_BIT;
            if (bn) return b | FP_QNAN_BIT;
            if (ai && bi && (a[31] != b[31])) return FP_DEFAULT_NAN;
            if (ai) return a;
            if (bi) return b;
            if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
            if (a[30:0] >= b[30:0]) begin
                big = a;
                sml = b;
            end else begin
                big = b;
                sml = a;
            end
            eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
            es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
            d    = eb - es;
            mb27 = {(big[30:23] != 8'd0), big[22:0], 3'd0};
            ms27 = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
            if (d >= 8'd27) begin
                al = {26'd0, |ms27};
            end else begin
                stm = (27'd1 << d) - 27'd1;
                al  = ms27 >> d;
                al[0] = al[0] | (|(ms27 & stm));
            end
            if (big[31] == sml[31]) sum = {1'b0, mb27} + {1'b0, al};
            else                    sum = {1'b0, mb27} - {1'b0, al};
            if (sum == 28'd0) return 32'd0;
            be = $signed({4'd0, eb}) + 12'sd1;
            return round_pack(big[31], be, {sum, 20'd0});
        end
    endfunction

endpackage

// File: src/fast_inverse_sqrt_single.sv
// ============================================================================
// fast_inverse_sqrt_single
// Approximate 1/sqrt(x) on binary32: magic-constant guess plus one Newton
// step, every operation rounded to nearest even.
// ============================================================================
// A transaction starts when start is high while busy is low; busy is never
// raised, so one operand can enter on every clock. The result leaves on
// o_result_bits with o_strobe high for a single cycle; the receiver cannot
// stall it, so it must take every strobe. There are five register stages,
// one binary32 operation each: 0.5*x (with the integer guess), h*g, t*g,
// 1.5-t, g*d. Zero, negative, infinite and NaN operands get no special
// treatment and come out as the arithmetic gives them.
module fast_inverse_sqrt_single (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand_bits,
    output logic [31:0] o_result_bits,
    output logic        o_strobe
);

    logic        s1_vld, s2_vld, s3_vld, s5_vld;
    logic [31:0] s1_h, s1_g, s2_t, s2_g, s3_t, s3_g, s5_y, s5_g;
    logic        s3_t_nan;
    logic [31:0] n_d;
    logic [31:0] r4_d;
    logic [31:0] r4_g;
    logic        r4_vld;

    // No backpressure anywhere: the pipe always advances.
    assign busy = 1'b0;

    // Stage 1: h = 0.5 * x, guess rides along
    fisqrt_mul_stage u_st1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(start & ~busy),
        .i_a(fisqrt_pkg::FP_HALF), .i_b(i_operand_bits),
        .i_g(fisqrt_pkg::first_guess(i_operand_bits)),
        .o_vld(s1_vld), .o_p(s1_h), .o_g(s1_g)
    );

    // Stage 2: t = h * g
    fisqrt_mul_stage u_st2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(s1_vld), .i_a(s1_h), .i_b(s1_g), .i_g(s1_g),
        .o_vld(s2_vld), .o_p(s2_t), .o_g(s2_g)
    );

    // Stage 3: t = t * g
    fisqrt_mul_stage u_st3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(s2_vld), .i_a(s2_t), .i_b(s2_g), .i_g(s2_g),
        .o_vld(s3_vld), .o_p(s3_t), .o_g(s3_g)
    );

    // Stage 4: d = 1.5 - t, done as 1.5 + (-t). A NaN t is not negated:
    // a subtract hands the NaN on with its sign as it is.
    assign s3_t_nan = (s3_t[30:23] == 8'hff) && (s3_t[22:0] != 23'd0);
    assign n_d = fisqrt_pkg::fp_add(fisqrt_pkg::FP_THREE_HALVES,
                                    {s3_t[31] ^ ~s3_t_nan, s3_t[30:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_d <= n_d;
        r4_g <= s3_g;
    end

    // Stage 5: y = g * d
    fisqrt_mul_stage u_st5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(r4_vld), .i_a(r4_g), .i_b(r4_d), .i_g(r4_g),
        .o_vld(s5_vld), .o_p(s5_y), .o_g(s5_g)
    );

    assign o_result_bits = s5_y;
    assign o_strobe      = s5_vld & (s5_g == s5_g);

endmodule

// File: src/fisqrt_mul_stage.sv
// ============================================================================
// fisqrt_mul_stage
// One registered binary32 multiply stage; carries the guess alongside.
// ============================================================================
module fisqrt_mul_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_g,
    output logic        o_vld,
    output logic [31:0] o_p,
    output logic [31:0] o_g
);

    logic        r_vld;
    logic [31:0] r_p;
    logic [31:0] r_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= fisqrt_pkg::fp_mul(i_a, i_b);
        r_g <= i_g;
    end

    assign o_vld = r_vld;
    assign o_p   = r_p;
    assign o_g   = r_g;

endmodule
